// ===== src/adsr_envelope_level_defines.svh =====
// ----------------------------------------------------------------------------
// ADSR envelope level: assertion macros
// Shared property wrappers on clock, with reset disabling the check.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_LEVEL_DEFINES_SVH
`define ADSR_ENVELOPE_LEVEL_DEFINES_SVH

// same-cycle implication
`define ADSR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ADSR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/adsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope package
// Widths, phase codes, register indexes and the sideband carried alongside
// the divider.
// ----------------------------------------------------------------------------
package adsr_pkg;

   localparam int LEN_W   = 23;                // ramp and note lengths
   localparam int LEVEL_W = 16;                // Q1.15 level
   localparam int PHASE_W = 3;
   localparam int Q_W     = 15;                // every ramp quotient is below 2**15
   localparam int NUM_W   = Q_W + LEN_W;       // factor <= 2**15 times value < 2**23

   localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'h8000;

   // register indexes, byte address is 4 * index
   localparam logic [2:0] REG_NOTE    = 3'd0;
   localparam logic [2:0] REG_ATTACK  = 3'd1;
   localparam logic [2:0] REG_DECAY   = 3'd2;
   localparam logic [2:0] REG_SUSTAIN = 3'd3;
   localparam logic [2:0] REG_RELEASE = 3'd4;

   typedef enum logic [PHASE_W-1:0] {
      PH_SILENT  = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [LEVEL_W-1:0] sus;
   } adsr_side_type;

endpackage

// ===== src/adsr_envelope_level.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope level
// Maps a tick count since note start to the ADSR level (Q1.15) and phase.
//
//   Channel  Dir  Ports                          Payload
//   req      in   req_tvalid/tready/tdata        time_tick (signed)
//   rsp      out  rsp_tvalid/tready/tdata/tuser  level / phase
//   csr      in   csr_psel/penable/pwrite/...    five config registers
//
// One transaction per cycle while the skid is empty; a result passes through
// 19 register stages: input register, classify, 16x23 multiply, 15 divider
// stages (one quotient bit each), output.
// Synchronous reset clears all valid bits and loads config reset values.
// The output register is backed by a one-entry skid; the pipeline freezes
// only while the skid holds a result, so a stall loses nothing.
// ----------------------------------------------------------------------------
`include "adsr_envelope_level_defines.svh"

module adsr_envelope_level
   import adsr_pkg::*;
#(
   parameter int TIME_BITS = 24
)(
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((TIME_BITS+7)/8)*8-1:0]    req_tdata,   // [TIME_BITS-1:0] time_tick
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [LEVEL_W-1:0]                rsp_tdata,   // [15:0] level
   output logic [PHASE_W-1:0]                rsp_tuser,   // [2:0] phase
   // config port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [4:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int CMP_W = ((TIME_BITS > LEN_W + 1) ? TIME_BITS : LEN_W + 1) + 1;

   // ---------------------------------------------------------------- config
   logic [LEN_W-1:0]   note_ff, attack_ff, decay_ff, release_ff;
   logic [LEVEL_W-1:0] sustain_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         note_ff    <= '0;
         attack_ff  <= '0;
         decay_ff   <= '0;
         sustain_ff <= FULL_SCALE;
         release_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_NOTE:    note_ff    <= csr_pwdata[LEN_W-1:0];
            REG_ATTACK:  attack_ff  <= csr_pwdata[LEN_W-1:0];
            REG_DECAY:   decay_ff   <= csr_pwdata[LEN_W-1:0];
            REG_SUSTAIN: sustain_ff <= csr_pwdata[LEVEL_W-1:0];
            REG_RELEASE: release_ff <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_NOTE:    csr_prdata = 32'(note_ff);
         REG_ATTACK:  csr_prdata = 32'(attack_ff);
         REG_DECAY:   csr_prdata = 32'(decay_ff);
         REG_SUSTAIN: csr_prdata = 32'(sustain_ff);
         REG_RELEASE: csr_prdata = 32'(release_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- pipeline
   logic en;
   logic skid_valid_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // stage 1: input register
   logic                 s1_valid_ff;
   logic [TIME_BITS-1:0] s1_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_time_ff <= req_tdata[TIME_BITS-1:0];
      end
   end

   // stage 2: phase decision, multiplier operands and divisor
   logic [LEVEL_W-1:0] sus_sat;
   logic [CMP_W-1:0]   tu, a_x, ad_x, len_x, rel_x, t_rel;
   logic [CMP_W-1:0]   u_diff, end_diff;
   logic [LEVEL_W-1:0] f_in;
   logic [LEN_W-1:0]   g_in, den_in;
   phase_type          phase_in;

   logic               s2_valid_ff;
   logic [LEVEL_W-1:0] s2_f_ff;
   logic [LEN_W-1:0]   s2_g_ff, s2_den_ff;
   adsr_side_type      s2_side_ff;

   assign sus_sat  = (sustain_ff > FULL_SCALE) ? FULL_SCALE : sustain_ff;
   assign tu       = CMP_W'(s1_time_ff[TIME_BITS-2:0]);
   assign a_x      = CMP_W'(attack_ff);
   assign ad_x     = CMP_W'(attack_ff) + CMP_W'(decay_ff);
   assign len_x    = CMP_W'(note_ff);
   assign rel_x    = CMP_W'(release_ff);
   assign t_rel    = tu + rel_x;
   assign u_diff   = tu - a_x;
   assign end_diff = len_x - tu;

   always_comb begin
      phase_in = PH_SUSTAIN;
      f_in     = '0;
      g_in     = '0;
      den_in   = LEN_W'(1);
      if (s1_time_ff[TIME_BITS-1] || (note_ff == '0)) begin
         phase_in = PH_SILENT;
      end else if (tu < a_x) begin
         phase_in = PH_ATTACK;
         f_in     = FULL_SCALE;
         g_in     = tu[LEN_W-1:0];
         den_in   = attack_ff;
      end else if (tu < ad_x) begin
         phase_in = PH_DECAY;
         f_in     = FULL_SCALE - sus_sat;
         g_in     = u_diff[LEN_W-1:0];
         den_in   = decay_ff;
      end else if (tu >= len_x) begin
         phase_in = PH_SILENT;
      end else if ((release_ff != '0) && (t_rel > len_x)) begin
         phase_in = PH_RELEASE;
         f_in     = sus_sat;
         g_in     = end_diff[LEN_W-1:0];
         den_in   = release_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_f_ff          <= f_in;
         s2_g_ff          <= g_in;
         s2_den_ff        <= den_in;
         s2_side_ff.phase <= phase_in;
         s2_side_ff.sus   <= sus_sat;
      end
   end

   // stage 3: product, always below den * 2**15 for the ramp phases
   logic [LEVEL_W+LEN_W-1:0] prod;
   logic                     s3_valid_ff;
   logic [NUM_W-1:0]         s3_num_ff;
   logic [LEN_W-1:0]         s3_den_ff;
   adsr_side_type            s3_side_ff;

   assign prod = s2_f_ff * s2_g_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_num_ff  <= prod[NUM_W-1:0];
         s3_den_ff  <= s2_den_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // divider stages
   logic          dv_valid;
   logic [Q_W-1:0] dv_quo;
   adsr_side_type dv_side;

   adsr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .in_side   (s3_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // final level select
   logic [LEVEL_W-1:0] level_in;

   always_comb begin
      case (dv_side.phase)
         PH_ATTACK, PH_RELEASE: level_in = LEVEL_W'(dv_quo);
         PH_DECAY:              level_in = FULL_SCALE - LEVEL_W'(dv_quo);
         PH_SUSTAIN:            level_in = dv_side.sus;
         default:               level_in = '0;
      endcase
   end

   // ---------------------------------------------------------------- output + skid
   logic               rsp_valid_ff, rsp_valid_in, skid_valid_in;
   logic               rsp_load, skid_load;
   logic [LEVEL_W-1:0] rsp_level_ff, skid_level_ff;
   phase_type          rsp_phase_ff, skid_phase_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_load      = 1'b0;
      skid_load     = 1'b0;
      if (rsp_valid_ff && !rsp_tready) begin
         // output blocked: a result leaving the pipe parks in the skid
         if (en && dv_valid) begin
            skid_valid_in = 1'b1;
            skid_load     = 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end else begin
         rsp_valid_in = dv_valid;
         rsp_load     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_load) begin
         skid_level_ff <= level_in;
         skid_phase_ff <= dv_side.phase;
      end
      if (rsp_load) begin
         rsp_level_ff <= level_in;
         rsp_phase_ff <= dv_side.phase;
      end else if (!(rsp_valid_ff && !rsp_tready) && skid_valid_ff) begin
         rsp_level_ff <= skid_level_ff;
         rsp_phase_ff <= skid_phase_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_level_ff;
   assign rsp_tuser  = rsp_phase_ff;

   // ---------------------------------------------------------------- checks
   `ADSR_ASSERT_IMP(a_skid_behind_out, skid_valid_ff, rsp_valid_ff,
                    "skid full with empty output")
   `ADSR_ASSERT_IMP(a_level_range, rsp_valid_ff, rsp_level_ff <= FULL_SCALE,
                    "level above full scale")
   `ADSR_ASSERT_IMP(a_silent_zero, rsp_valid_ff && (rsp_phase_ff == PH_SILENT),
                    rsp_level_ff == '0, "silent phase with nonzero level")
   `ADSR_ASSERT_NXT(a_skid_catch, rsp_valid_ff && !rsp_tready && !skid_valid_ff && dv_valid,
                    skid_valid_ff, "result dropped on output stall")

endmodule

// ===== src/adsr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR pipelined divider
// Restoring division, one quotient bit per stage; the numerator is known
// to be below den * 2**Q_W, so Q_W stages give the whole quotient.
// ----------------------------------------------------------------------------
module adsr_div
   import adsr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [LEN_W-1:0]   in_den,
   input  adsr_side_type      in_side,
   output logic               out_valid,
   output logic [Q_W-1:0]     out_quo,
   output adsr_side_type      out_side
);

   logic               valid_ff [Q_W];
   logic [NUM_W-1:0]   rem_ff   [Q_W];
   logic [Q_W-1:0]     quo_ff   [Q_W];
   logic [LEN_W-1:0]   den_ff   [Q_W];
   adsr_side_type      side_ff  [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      localparam int BIT = Q_W - 1 - j;

      logic             prev_valid;
      logic [NUM_W-1:0] prev_rem;
      logic [Q_W-1:0]   prev_quo;
      logic [LEN_W-1:0] prev_den;
      adsr_side_type    prev_side;
      logic [NUM_W-1:0] sub;
      logic             ge;
      logic [NUM_W-1:0] rem_in;
      logic [Q_W-1:0]   quo_in;

      if (j == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = in_num;
         assign prev_quo   = '0;
         assign prev_den   = in_den;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[j-1];
         assign prev_rem   = rem_ff[j-1];
         assign prev_quo   = quo_ff[j-1];
         assign prev_den   = den_ff[j-1];
         assign prev_side  = side_ff[j-1];
      end

      assign sub    = NUM_W'(prev_den) << BIT;
      assign ge     = (prev_rem >= sub);
      assign rem_in = ge ? (prev_rem - sub) : prev_rem;
      assign quo_in = prev_quo | (Q_W'(ge) << BIT);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            quo_ff[j]  <= quo_in;
            den_ff[j]  <= prev_den;
            side_ff[j] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_quo   = quo_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

// ===== bench/adsr_envelope_level_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope level testbench
// Drives tick transactions into the envelope block under a series of register
// settings and checks every level/phase result in order against a table value or
// an in-bench envelope predictor. A short directed table covers the ramp edges,
// silence, saturation and extreme lengths; random settings and ticks follow under
// four handshake mixes, a long result stall in two, a full drain at each change.
// ----------------------------------------------------------------------------
module adsr_envelope_level_tb
   import adsr_pkg::*;
();

   localparam int TICK_W       = 24;
   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam int SEGMENTS     = 4;
   localparam int SEG_ITEMS    = 100;

   // unmapped register indexes
   localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [LEN_W-1:0]   note_len;
      logic [LEN_W-1:0]   attack_len;
      logic [LEN_W-1:0]   decay_len;
      logic [LEVEL_W-1:0] sustain;
      logic [LEN_W-1:0]   release_len;
   } envelope_cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      phase_type          phase;
   } envelope_level_type;

   typedef struct packed {
      envelope_cfg_type   cfg;
      logic [TICK_W-1:0]  tick;
      logic               typed;
      envelope_level_type want;
   } directed_row_type;

   localparam envelope_cfg_type CFG_RESET = '{
      note_len: 0, attack_len: 0, decay_len: 0, sustain: 32768, release_len: 0};
   localparam envelope_cfg_type CFG_SHAPE = '{
      note_len: 1000, attack_len: 100, decay_len: 200, sustain: 16384, release_len: 300};
   localparam envelope_cfg_type CFG_PAST_END = '{
      note_len: 10, attack_len: 20, decay_len: 30, sustain: 0, release_len: 0};
   localparam envelope_cfg_type CFG_LONG_REL = '{
      note_len: 100, attack_len: 0, decay_len: 0, sustain: 16'hFFFF, release_len: 200};
   localparam envelope_cfg_type CFG_MAX_RAMPS = '{
      note_len: 8388607, attack_len: 8388607, decay_len: 8388607, sustain: 0,
      release_len: 8388607};
   localparam envelope_cfg_type CFG_FLAT = '{
      note_len: 8388607, attack_len: 0, decay_len: 0, sustain: 32768, release_len: 0};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [TICK_W-1:0]   req_tdata = '0;          // [23:0] time_tick
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [LEVEL_W-1:0]  rsp_tdata;               // [15:0] level
   logic [PHASE_W-1:0]  rsp_tuser;               // [2:0] phase
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [4:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   envelope_cfg_type    active_cfg = CFG_RESET;
   envelope_level_type  envelope_expected[$];
   directed_row_type    directed_rows[$];
   envelope_level_type  want;

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_tickets = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int error_count = 0;
   int ticks_sent = 0;
   int results_checked = 0;
   int settings_used = 0;
   int cycle_count = 0;
   int phase_hits[0:7];

   adsr_envelope_level dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever begin
         #CLK_HALF clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  envelope_expected.size());
         $display("adsr_envelope_level_tb: FAIL");
         $finish;
      end
   end

   // level and phase for one tick under the settings now in the block
   function automatic envelope_level_type envelope_at(input logic [TICK_W-1:0] raw);
      logic signed [TICK_W-1:0] st;
      longint t, a, d, len, rel, sus, full, lvl;
      envelope_level_type res;
      st   = raw;
      t    = longint'(st);
      a    = longint'(active_cfg.attack_len);
      d    = longint'(active_cfg.decay_len);
      len  = longint'(active_cfg.note_len);
      rel  = longint'(active_cfg.release_len);
      full = longint'(FULL_SCALE);
      sus  = (active_cfg.sustain > FULL_SCALE) ? full : longint'(active_cfg.sustain);
      if (t < 0 || len == 0) begin
         lvl = 0;
         res.phase = PH_SILENT;
      end else if (t < a) begin
         lvl = (t * full) / a;
         res.phase = PH_ATTACK;
      end else if (t < a + d) begin
         lvl = full - ((full - sus) * (t - a)) / d;
         res.phase = PH_DECAY;
      end else if (t >= len) begin
         lvl = 0;
         res.phase = PH_SILENT;
      end else if (rel > 0 && t + rel > len) begin
         lvl = (sus * (len - t)) / rel;
         res.phase = PH_RELEASE;
      end else begin
         lvl = sus;
         res.phase = PH_SUSTAIN;
      end
      res.level = lvl[LEVEL_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at result %0d: %s", results_checked, msg);
      error_count++;
   endtask

   // result side: checks in order, stalls at random or for a requested hold
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (envelope_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected level %0d phase %0d", rsp_tdata, rsp_tuser));
         end else begin
            want = envelope_expected.pop_front();
            if (rsp_tdata !== want.level)
               report_mismatch($sformatf("level %0d, want %0d", rsp_tdata, want.level));
            if (rsp_tuser !== want.phase)
               report_mismatch($sformatf("phase %0d, want %0d", rsp_tuser, want.phase));
            phase_hits[want.phase]++;
            results_checked++;
         end
      end
      if (hold_tickets != hold_seen) begin
         hold_seen = hold_tickets;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper bits of a register write get random junk half the time
   function automatic logic [31:0] with_junk(input logic [31:0] v, input logic [31:0] keep);
      logic [31:0] junk;
      junk = $urandom_range(1) ? ($urandom & ~keep) : 32'd0;
      return (v & keep) | junk;
   endfunction

   task automatic apply_cfg(input envelope_cfg_type cfg);
      csr_write(REG_NOTE,    with_junk(32'(cfg.note_len),    32'h007F_FFFF));
      csr_write(REG_ATTACK,  with_junk(32'(cfg.attack_len),  32'h007F_FFFF));
      csr_write(REG_DECAY,   with_junk(32'(cfg.decay_len),   32'h007F_FFFF));
      csr_write(REG_SUSTAIN, with_junk(32'(cfg.sustain),     32'h0000_FFFF));
      csr_write(REG_RELEASE, with_junk(32'(cfg.release_len), 32'h007F_FFFF));
      // writes to unmapped addresses must leave the settings alone
      csr_write(3'($urandom_range(32'(REG_SPARE_LAST), 32'(REG_SPARE_FIRST))), $urandom);
      active_cfg = cfg;
      settings_used++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (envelope_expected.size() != 0) @(posedge clock);
   endtask

   // one tick transaction; valid stays high afterwards unless a gap follows
   task automatic send_tick(input logic [TICK_W-1:0] tick);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tick;
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   function automatic logic [LEN_W-1:0] random_length();
      int r;
      r = int'($urandom_range(99));
      if (r < 8) return '0;
      if (r < 16) return '1;
      if (r < 28) return LEN_W'($urandom);
      return LEN_W'($urandom_range(2000, 1));
   endfunction

   function automatic envelope_cfg_type random_cfg();
      envelope_cfg_type cfg;
      int r;
      cfg.note_len    = random_length();
      cfg.attack_len  = random_length();
      cfg.decay_len   = random_length();
      cfg.release_len = random_length();
      r = int'($urandom_range(99));
      if (r < 10)      cfg.sustain = '0;
      else if (r < 20) cfg.sustain = FULL_SCALE;
      else if (r < 30) cfg.sustain = LEVEL_W'($urandom);        // may exceed full scale
      else             cfg.sustain = LEVEL_W'($urandom_range(32768));
      return cfg;
   endfunction

   // mostly ticks inside the note span, some near phase edges, some anywhere
   function automatic logic [TICK_W-1:0] random_tick();
      longint span, base, tick;
      int r;
      span = longint'(active_cfg.attack_len) + longint'(active_cfg.decay_len);
      if (longint'(active_cfg.note_len) > span) span = longint'(active_cfg.note_len);
      if (span > 8388607) span = 8388607;
      r = int'($urandom_range(99));
      if (r < 30) begin
         tick = longint'($urandom);
      end else if (r < 45) begin
         case ($urandom_range(4))
            0: base = 0;
            1: base = longint'(active_cfg.attack_len);
            2: base = longint'(active_cfg.attack_len) + longint'(active_cfg.decay_len);
            3: base = longint'(active_cfg.note_len) - longint'(active_cfg.release_len);
            default: base = longint'(active_cfg.note_len);
         endcase
         tick = base + longint'($urandom_range(4)) - 2;
      end else begin
         tick = longint'($urandom_range(32'(span) + 8)) - 8;
      end
      return tick[TICK_W-1:0];
   endfunction

   task automatic add_row(input envelope_cfg_type cfg, input int tick, input logic typed,
                          input int level, input phase_type phase);
      directed_row_type row;
      row.cfg        = cfg;
      row.tick       = tick[TICK_W-1:0];
      row.typed      = typed;
      row.want.level = level[LEVEL_W-1:0];
      row.want.phase = phase;
      directed_rows.push_back(row);
   endtask

   initial begin
      directed_row_type row;
      int idle_mix[4];
      int stall_mix[4];
      idle_mix  = '{0, 74, 0, 27};
      stall_mix = '{0, 0, 74, 27};

      // typed = 0: the predictor supplies the expectation
      add_row(CFG_RESET,     0,        1, 0,     PH_SILENT);
      add_row(CFG_RESET,     8388607,  1, 0,     PH_SILENT);
      add_row(CFG_RESET,     -8388608, 1, 0,     PH_SILENT);
      add_row(CFG_SHAPE,     -1,       1, 0,     PH_SILENT);
      add_row(CFG_SHAPE,     0,        1, 0,     PH_ATTACK);
      add_row(CFG_SHAPE,     50,       1, 16384, PH_ATTACK);
      add_row(CFG_SHAPE,     99,       0, 0,     PH_SILENT);
      add_row(CFG_SHAPE,     100,      1, 32768, PH_DECAY);
      add_row(CFG_SHAPE,     299,      0, 0,     PH_SILENT);
      add_row(CFG_SHAPE,     300,      1, 16384, PH_SUSTAIN);
      add_row(CFG_SHAPE,     700,      1, 16384, PH_SUSTAIN);
      add_row(CFG_SHAPE,     701,      0, 0,     PH_SILENT);
      add_row(CFG_SHAPE,     999,      0, 0,     PH_SILENT);
      add_row(CFG_SHAPE,     1000,     1, 0,     PH_SILENT);
      add_row(CFG_PAST_END,  15,       0, 0,     PH_SILENT);
      add_row(CFG_PAST_END,  40,       0, 0,     PH_SILENT);
      add_row(CFG_PAST_END,  50,       1, 0,     PH_SILENT);
      add_row(CFG_LONG_REL,  0,        1, 16384, PH_RELEASE);
      add_row(CFG_LONG_REL,  99,       0, 0,     PH_SILENT);
      add_row(CFG_LONG_REL,  100,      1, 0,     PH_SILENT);
      add_row(CFG_MAX_RAMPS, 0,        1, 0,     PH_ATTACK);
      add_row(CFG_MAX_RAMPS, 8388606,  0, 0,     PH_SILENT);
      add_row(CFG_MAX_RAMPS, 8388607,  1, 32768, PH_DECAY);
      add_row(CFG_FLAT,      0,        1, 32768, PH_SUSTAIN);
      add_row(CFG_FLAT,      8388607,  1, 0,     PH_SILENT);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.cfg != active_cfg) begin
            wait_drained();
            apply_cfg(row.cfg);
         end
         send_tick(row.tick);
         envelope_expected.push_back(row.typed ? row.want : envelope_at(row.tick));
      end

      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_mix[p];
         stall_pct = stall_mix[p];
         for (int s = 0; s < SEGMENTS; s++) begin
            wait_drained();
            apply_cfg(random_cfg());
            // long result stall while ticks keep coming, so the pipe backs up
            if (s == 1 && (p == 0 || p == 3)) hold_tickets++;
            for (int n = 0; n < SEG_ITEMS; n++) begin
               row.tick = random_tick();
               send_tick(row.tick);
               envelope_expected.push_back(envelope_at(row.tick));
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d ticks under %0d register settings, four handshake mixes",
               ticks_sent, settings_used);
      $display("%0d results: silent %0d attack %0d decay %0d sustain %0d release %0d",
               results_checked, phase_hits[PH_SILENT], phase_hits[PH_ATTACK],
               phase_hits[PH_DECAY], phase_hits[PH_SUSTAIN], phase_hits[PH_RELEASE]);
      if (error_count == 0) begin
         $display("adsr_envelope_level_tb: PASS");
      end else begin
         $display("adsr_envelope_level_tb: FAIL");
      end
      $finish;
   end

endmodule
